// File: src/clps_pkg.sv
// ----------------------------------------------------------------------------
// clps_pkg: shared types and constants
// Opcodes, field widths and the pin pair lookup for the charlieplex scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package clps_pkg;

  localparam int OP_W     = 2;
  localparam int IDX_W    = 7;
  localparam int VAL_W    = 8;
  localparam int PIN_W    = 11;
  localparam int PINSEL_W = 4;
  localparam int SHIFT_W  = 4;
  localparam int BRIGHT_W = VAL_W + 3;
  localparam int R23_W    = 5;
  localparam int R15_W    = 4;
  // groups needed to cover the largest supported matrix
  localparam int MAX_GROUP = 10;

  localparam logic [SHIFT_W-1:0] SHIFT_RESET = 4'd3;
  localparam logic [R23_W-1:0]   R23_LAST    = 5'd22;
  localparam logic [R15_W-1:0]   R15_LAST    = 4'd14;

  typedef enum logic [OP_W-1:0] {
    OP_TICK    = 2'd0,
    OP_BIN_WR  = 2'd1,
    OP_GRAY_WR = 2'd2
  } op_t;

  typedef struct packed {
    logic [PINSEL_W-1:0] hi;
    logic [PINSEL_W-1:0] lo;
  } pin_pair_t;

  // front end to frame store
  typedef struct packed {
    logic             bin_we;
    logic             gray_we;
    logic [IDX_W-1:0] wr_addr;
    logic [VAL_W-1:0] wr_data;
    logic             rd_en;
    logic [IDX_W-1:0] rd_led;
  } mem_req_t;

  // tick context held next to the registered memory data
  typedef struct packed {
    logic             valid;
    logic             gray;
    logic [IDX_W-1:0] led;
    pin_pair_t        pair;
    logic             pair_ok;
    logic             z23;
    logic             z15;
    logic             z5;
    logic             z3;
  } tick_ctx_t;

  // group k starts at LED k*(k-1): (0,k),(k,0),(1,k),(k,1),...
  function automatic pin_pair_t pin_pair(input logic [IDX_W-1:0] led);
    int        k;
    int        off;
    pin_pair_t p;
    k = 1;
    for (int j = 1; j <= MAX_GROUP; j++) begin
      if (j * (j + 1) <= int'(led)) k++;
    end
    off = int'(led) - k * (k - 1);
    if (off % 2 == 0) begin
      p.hi = PINSEL_W'(off / 2);
      p.lo = PINSEL_W'(k);
    end else begin
      p.hi = PINSEL_W'(k);
      p.lo = PINSEL_W'(off / 2);
    end
    return p;
  endfunction

endpackage

`default_nettype wire

// File: src/clps_if.sv
// ----------------------------------------------------------------------------
// clps_if: channel interfaces
// Command channel in, scan result channel out; valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface clps_cmd_if;
  import clps_pkg::*;
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  opcode;
  logic [IDX_W-1:0] index;
  logic [VAL_W-1:0] value;
  modport source (output valid, output opcode, output index, output value, input ready);
  modport sink   (input valid, input opcode, input index, input value, output ready);
endinterface

interface clps_scan_if;
  import clps_pkg::*;
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] led_index;
  logic [PIN_W-1:0] pin_drive_mask;
  logic [PIN_W-1:0] pin_high_mask;
  modport source (output valid, output led_index, output pin_drive_mask,
                  output pin_high_mask, input ready);
  modport sink   (input valid, input led_index, input pin_drive_mask,
                  input pin_high_mask, output ready);
endinterface

`default_nettype wire

// File: src/clps_frame_store.sv
// ----------------------------------------------------------------------------
// clps_frame_store: binary and grayscale frame memories
// One write and one registered read per cycle; per-entry valid bits make
// never-written entries read as zero right after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module clps_frame_store #(
  parameter int NUM_LEDS = 104
) (
  input  wire                       clk,
  input  wire                       rst,
  input  clps_pkg::mem_req_t        req,
  output logic [clps_pkg::VAL_W-1:0] bin_byte,
  output logic [clps_pkg::VAL_W-1:0] gray_level
);
  import clps_pkg::*;

  localparam int FRAME_BYTES = (NUM_LEDS + 7) / 8;
  localparam int BIN_AW      = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
  localparam int GRAY_AW     = $clog2(NUM_LEDS);

  logic [VAL_W-1:0] bin_mem  [FRAME_BYTES];
  logic [VAL_W-1:0] gray_mem [NUM_LEDS];
  logic [FRAME_BYTES-1:0] bin_vld;
  logic [NUM_LEDS-1:0]    gray_vld;

  logic [IDX_W-1:0]   rd_byte;
  logic [BIN_AW-1:0]  bin_wa;
  logic [BIN_AW-1:0]  bin_ra;
  logic [GRAY_AW-1:0] gray_wa;
  logic [GRAY_AW-1:0] gray_ra;

  assign rd_byte = req.rd_led >> 3;
  assign bin_wa  = req.wr_addr[BIN_AW-1:0];
  assign bin_ra  = rd_byte[BIN_AW-1:0];
  assign gray_wa = req.wr_addr[GRAY_AW-1:0];
  assign gray_ra = req.rd_led[GRAY_AW-1:0];

  always_ff @(posedge clk) begin
    if (req.bin_we) begin
      bin_mem[bin_wa] <= req.wr_data;
    end
    if (req.gray_we) begin
      gray_mem[gray_wa] <= req.wr_data;
    end
    if (req.rd_en) begin
      bin_byte   <= bin_vld[bin_ra] ? bin_mem[bin_ra] : '0;
      gray_level <= gray_vld[gray_ra] ? gray_mem[gray_ra] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bin_vld  <= '0;
      gray_vld <= '0;
    end else begin
      if (req.bin_we) bin_vld[bin_wa] <= 1'b1;
      if (req.gray_we) gray_vld[gray_wa] <= 1'b1;
    end
  end

endmodule

`default_nettype wire

// File: src/clps_scan_ctrl.sv
// ----------------------------------------------------------------------------
// clps_scan_ctrl: command decode and scan state
// Decodes words, issues frame writes and reads, advances scan position and
// PWM phase, and registers the tick context for the lit stage.
// ----------------------------------------------------------------------------
`default_nettype none

module clps_scan_ctrl #(
  parameter int NUM_LEDS = 104,
  parameter int NUM_PINS = 11
) (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         accept,
  input  wire                         advance,
  input  wire [clps_pkg::OP_W-1:0]    opcode,
  input  wire [clps_pkg::IDX_W-1:0]   index,
  input  wire [clps_pkg::VAL_W-1:0]   value,
  output clps_pkg::mem_req_t          req,
  output clps_pkg::tick_ctx_t         ctx
);
  import clps_pkg::*;

  localparam int FRAME_BYTES = (NUM_LEDS + 7) / 8;
  localparam logic [IDX_W-1:0] LAST_LED = IDX_W'(NUM_LEDS - 1);

  logic             scan_pos;
  logic [IDX_W-1:0] scan_position;
  logic [R23_W-1:0] r23;
  logic [R15_W-1:0] r15;
  logic             grayscale_mode;
  logic             tick;
  pin_pair_t        pair;

  assign scan_pos = 1'b0;
  assign tick = accept && (opcode == OP_TICK);
  assign pair = pin_pair(scan_position);

  always_comb begin
    req.bin_we  = accept && (opcode == OP_BIN_WR) && (int'(index) < FRAME_BYTES);
    req.gray_we = accept && (opcode == OP_GRAY_WR) && (int'(index) < NUM_LEDS);
    req.wr_addr = index;
    req.wr_data = value;
    req.rd_en   = tick;
    req.rd_led  = scan_position | IDX_W'(scan_pos);
  end

  always_ff @(posedge clk) begin
    if (tick) begin
      ctx.gray    <= grayscale_mode;
      ctx.led     <= scan_position;
      ctx.pair    <= pair;
      ctx.pair_ok <= (int'(pair.hi) < NUM_PINS) && (int'(pair.lo) < NUM_PINS);
      ctx.z23     <= (r23 == '0);
      ctx.z15     <= (r15 == '0);
      ctx.z5      <= (r15 == 4'd0) || (r15 == 4'd5) || (r15 == 4'd10);
      ctx.z3      <= (r15 == 4'd0) || (r15 == 4'd3) || (r15 == 4'd6) ||
                     (r15 == 4'd9) || (r15 == 4'd12);
    end
    if (rst) begin
      scan_position  <= '0;
      r23            <= '0;
      r15            <= '0;
      grayscale_mode <= 1'b0;
      ctx.valid      <= 1'b0;
    end else begin
      if (accept && opcode == OP_BIN_WR) grayscale_mode <= 1'b0;
      if (accept && opcode == OP_GRAY_WR) grayscale_mode <= 1'b1;
      if (tick) begin
        scan_position <= (scan_position == LAST_LED) ? '0 : scan_position + 1'b1;
        // phase mod 345 kept as its residues mod 23 and mod 15
        if (grayscale_mode) begin
          r23 <= (r23 == R23_LAST) ? '0 : r23 + 1'b1;
          r15 <= (r15 == R15_LAST) ? '0 : r15 + 1'b1;
        end
        ctx.valid <= 1'b1;
      end else if (advance) begin
        ctx.valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// File: src/clps_out_stage.sv
// ----------------------------------------------------------------------------
// clps_out_stage: lit decision and result register
// Turns the read frame data into an on/off decision and the pin masks, and
// holds the result word until the sink takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module clps_out_stage (
  input  wire                          clk,
  input  wire                          rst,
  input  clps_pkg::tick_ctx_t          ctx,
  input  wire [clps_pkg::VAL_W-1:0]    bin_byte,
  input  wire [clps_pkg::VAL_W-1:0]    gray_level,
  input  wire [clps_pkg::SHIFT_W-1:0]  gray_shift,
  output logic                         advance,
  clps_scan_if.source                  scan
);
  import clps_pkg::*;

  logic [BRIGHT_W-1:0] bright;
  logic                gray_on;
  logic                on;
  logic [PIN_W-1:0]    hi_bit;
  logic [PIN_W-1:0]    lo_bit;

  assign bright = {gray_level, 3'b000} >> gray_shift;

  always_comb begin
    case (bright)
      BRIGHT_W'(0): gray_on = 1'b0;
      BRIGHT_W'(1): gray_on = ctx.z23;
      BRIGHT_W'(2): gray_on = ctx.z15;
      BRIGHT_W'(3): gray_on = ctx.z5;
      BRIGHT_W'(4): gray_on = ctx.z3;
      default:      gray_on = 1'b1;
    endcase
  end

  assign on = ctx.gray ? gray_on : bin_byte[ctx.led[2:0]];
  assign hi_bit = PIN_W'(1) << ctx.pair.hi;
  assign lo_bit = PIN_W'(1) << ctx.pair.lo;
  assign advance = !scan.valid || scan.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      scan.valid <= 1'b0;
    end else if (advance) begin
      scan.valid <= ctx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && ctx.valid) begin
      scan.led_index <= ctx.led;
      if (on && ctx.pair_ok) begin
        scan.pin_drive_mask <= hi_bit | lo_bit;
        scan.pin_high_mask  <= hi_bit;
      end else begin
        scan.pin_drive_mask <= '0;
        scan.pin_high_mask  <= '0;
      end
    end
  end

endmodule

`default_nettype wire

// File: src/charlieplex_led_scanner_unit.sv
// ----------------------------------------------------------------------------
// charlieplex_led_scanner_unit: charlieplexed LED matrix scanner
// Holds binary and grayscale frames in memory and emits pin masks per tick.
// ----------------------------------------------------------------------------
// A tick word's result goes through the frame memory read register, then
//   the lit decision into the result register.
// One word per cycle unless the sink stalls; writes give no result word.
// Frame writes and tick reads all happen at the acceptance edge, in order.
// Reset: frames read as zero at once through per-entry valid bits, no
//   clearing pass; scan position and phase zero, binary mode, gray_shift 3.
`default_nettype none

module charlieplex_led_scanner_unit #(
  parameter int NUM_LEDS = 104,
  parameter int NUM_PINS = 11
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          cfg_we,
  input  wire [clps_pkg::SHIFT_W-1:0]  cfg_data,
  clps_cmd_if.sink                     cmd,
  clps_scan_if.source                  scan
);
  import clps_pkg::*;

  logic [SHIFT_W-1:0] gray_shift;
  logic               accept;
  logic               advance;
  mem_req_t           req;
  tick_ctx_t          ctx;
  logic [VAL_W-1:0]   bin_byte;
  logic [VAL_W-1:0]   gray_level;

  assign cmd.ready = !ctx.valid || advance;
  assign accept    = cmd.valid && cmd.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      gray_shift <= SHIFT_RESET;
    end else if (cfg_we) begin
      gray_shift <= cfg_data;
    end
  end

  clps_scan_ctrl #(.NUM_LEDS(NUM_LEDS), .NUM_PINS(NUM_PINS)) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .advance (advance),
    .opcode  (cmd.opcode),
    .index   (cmd.index),
    .value   (cmd.value),
    .req     (req),
    .ctx     (ctx)
  );

  clps_frame_store #(.NUM_LEDS(NUM_LEDS)) u_store (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .bin_byte   (bin_byte),
    .gray_level (gray_level)
  );

  clps_out_stage u_out (
    .clk        (clk),
    .rst        (rst),
    .ctx        (ctx),
    .bin_byte   (bin_byte),
    .gray_level (gray_level),
    .gray_shift (gray_shift),
    .advance    (advance),
    .scan       (scan)
  );

  // both stages full and the sink stalled: no room for another word
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    (ctx.valid && scan.valid && !scan.ready) |-> !cmd.ready)
    else $error("command taken with both stages full");

  a_led_range: assert property (@(posedge clk) disable iff (rst)
    ctx.valid |-> (int'(ctx.led) < NUM_LEDS))
    else $error("scan position out of range");

  a_high_in_drive: assert property (@(posedge clk) disable iff (rst)
    scan.valid |-> ((scan.pin_high_mask & ~scan.pin_drive_mask) == '0))
    else $error("high pin not driven");

  a_two_pins: assert property (@(posedge clk) disable iff (rst)
    scan.valid |-> ($countones(scan.pin_drive_mask) == 0 ||
                    $countones(scan.pin_drive_mask) == 2))
    else $error("drive mask must select zero or two pins");

  a_tick_reads: assert property (@(posedge clk) disable iff (rst)
    (accept && cmd.opcode == OP_TICK) |=> ctx.valid)
    else $error("tick word lost before the lit stage");

endmodule

`default_nettype wire
